@@ hdl/smts_pkg.sv @@
`timescale 1ns / 1ps
package smts_pkg;

	localparam int unsigned CNT_W = 16;
	localparam logic [CNT_W-1:0] SAT_MAX = 16'd65000;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_HOLD        = 4'd1,
		PH_SWITCH      = 4'd2,
		PH_SETTLE      = 4'd3,
		PH_WAIT_REL    = 4'd4,
		PH_REL_DEB     = 4'd5,
		PH_RUN         = 4'd6,
		PH_WAIT_STOP   = 4'd7,
		PH_STOP_DEB    = 4'd8,
		PH_SWITCH_STOP = 4'd9,
		PH_POST        = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		LED_OFF = 2'd0,
		LED_UP  = 2'd1,
		LED_DN  = 2'd2
	} led_t;

	typedef enum logic [2:0] {
		REG_HOLD        = 3'd0,
		REG_RUN_LIMIT   = 3'd1,
		REG_SWITCH      = 3'd2,
		REG_SETTLE      = 3'd3,
		REG_REL_TIMEOUT = 3'd4,
		REG_REL_DEB     = 3'd5,
		REG_POST        = 3'd6
	} reg_idx_t;

	localparam logic BTN_UP   = 1'b0;
	localparam logic BTN_DOWN = 1'b1;

	localparam logic [CNT_W-1:0] RST_HOLD        = 16'd20;
	localparam logic [CNT_W-1:0] RST_RUN_LIMIT   = 16'd350;
	localparam logic [CNT_W-1:0] RST_SWITCH      = 16'd10;
	localparam logic [CNT_W-1:0] RST_SETTLE      = 16'd4;
	localparam logic [CNT_W-1:0] RST_REL_TIMEOUT = 16'd600;
	localparam logic [CNT_W-1:0] RST_REL_DEB     = 16'd10;
	localparam logic [CNT_W-1:0] RST_POST        = 16'd20;

	typedef struct packed {
		logic [CNT_W-1:0] hold_ticks;
		logic [CNT_W-1:0] run_limit_ticks;
		logic [CNT_W-1:0] switch_delay_ticks;
		logic [CNT_W-1:0] settle_ticks;
		logic [CNT_W-1:0] release_timeout_ticks;
		logic [CNT_W-1:0] release_debounce_ticks;
		logic [CNT_W-1:0] post_delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic sample_valid;
		logic up_pressed;
		logic down_pressed;
	} item_t;

	typedef struct packed {
		logic   motor_drive;
		logic   direction_up;
		led_t   led_mode;
		phase_t phase;
	} result_t;

	function automatic logic delay_done(input logic [CNT_W-1:0] cnt,
		input logic [CNT_W-1:0] limit);
		logic [CNT_W-1:0] lim;
		lim = (limit > SAT_MAX) ? SAT_MAX : limit;
		return cnt >= lim;
	endfunction

endpackage

@@ hdl/smts_fsm.sv @@
`timescale 1ns / 1ps
module smts_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  smts_pkg::item_t  item,
	input  smts_pkg::cfg_t   cfg,
	output smts_pkg::result_t result
);
	import smts_pkg::*;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] delay_q, delay_d;
	logic [CNT_W-1:0] run_q, run_d;
	logic             run_active_q, run_active_d;
	logic             chosen_q, chosen_d;
	logic             motor_q, motor_d;
	logic             dir_q, dir_d;
	led_t             led_q, led_d;

	logic             chosen_pressed;

	assign chosen_pressed = (chosen_q == BTN_DOWN) ? item.down_pressed : item.up_pressed;

	always_comb begin
		logic [CNT_W-1:0] dcnt;
		logic [CNT_W-1:0] rcnt;
		dcnt = delay_q;
		rcnt = run_q;
		if (item.tick) begin
			if (delay_q < SAT_MAX) dcnt = delay_q + 1'b1;
			if (run_active_q && (run_q < SAT_MAX)) rcnt = run_q + 1'b1;
		end
		phase_d      = phase_q;
		delay_d      = dcnt;
		run_d        = rcnt;
		run_active_d = run_active_q;
		chosen_d     = chosen_q;
		motor_d      = motor_q;
		dir_d        = dir_q;
		led_d        = led_q;
		case (phase_q)
			PH_HOLD: begin
				if (delay_done(dcnt, cfg.hold_ticks)) begin
					motor_d = 1'b0;
					phase_d = PH_SWITCH;
					delay_d = '0;
				end else if (item.sample_valid && !chosen_pressed) begin
					led_d   = LED_OFF;
					phase_d = PH_POST;
					delay_d = '0;
				end
			end
			PH_SWITCH: begin
				if (delay_done(dcnt, cfg.switch_delay_ticks)) begin
					dir_d   = (chosen_q == BTN_UP);
					phase_d = PH_SETTLE;
					delay_d = '0;
				end
			end
			PH_SETTLE: begin
				if (delay_done(dcnt, cfg.settle_ticks)) begin
					motor_d      = 1'b1;
					run_d        = '0;
					run_active_d = 1'b1;
					phase_d      = PH_WAIT_REL;
					delay_d      = '0;
				end
			end
			PH_WAIT_REL, PH_WAIT_STOP: begin
				if ((dcnt > cfg.release_timeout_ticks) ||
					(item.sample_valid && !chosen_pressed)) begin
					phase_d = (phase_q == PH_WAIT_REL) ? PH_REL_DEB : PH_STOP_DEB;
					delay_d = '0;
				end
			end
			PH_REL_DEB: begin
				if (delay_done(dcnt, cfg.release_debounce_ticks)) begin
					phase_d = PH_RUN;
					delay_d = '0;
				end
			end
			PH_RUN: begin
				if (rcnt > cfg.run_limit_ticks) begin
					motor_d      = 1'b0;
					run_active_d = 1'b0;
					phase_d      = PH_SWITCH_STOP;
					delay_d      = '0;
				end else if (item.sample_valid && (item.up_pressed || item.down_pressed)) begin
					motor_d  = 1'b0;
					chosen_d = item.up_pressed ? BTN_UP : BTN_DOWN;
					phase_d  = PH_WAIT_STOP;
					delay_d  = '0;
				end
			end
			PH_STOP_DEB: begin
				if (delay_done(dcnt, cfg.release_debounce_ticks)) begin
					phase_d = PH_SWITCH_STOP;
					delay_d = '0;
				end
			end
			PH_SWITCH_STOP: begin
				if (delay_done(dcnt, cfg.switch_delay_ticks)) begin
					dir_d   = 1'b0;
					led_d   = LED_OFF;
					phase_d = PH_POST;
					delay_d = '0;
				end
			end
			PH_POST: begin
				if (delay_done(dcnt, cfg.post_delay_ticks)) phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.sample_valid) begin
					if (item.up_pressed) begin
						chosen_d = BTN_UP;
						led_d    = LED_UP;
						phase_d  = PH_HOLD;
						delay_d  = '0;
					end else if (item.down_pressed) begin
						chosen_d = BTN_DOWN;
						led_d    = LED_DN;
						phase_d  = PH_HOLD;
						delay_d  = '0;
					end else begin
						led_d = LED_OFF;
					end
				end
			end
		endcase
	end

	// The result of an item is the state after its update.
	always_comb begin
		result.motor_drive  = motor_d;
		result.direction_up = dir_d;
		result.led_mode     = led_d;
		result.phase        = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			delay_q      <= '0;
			run_q        <= '0;
			run_active_q <= 1'b0;
			chosen_q     <= BTN_UP;
			motor_q      <= 1'b0;
			dir_q        <= 1'b0;
			led_q        <= LED_OFF;
		end else if (step) begin
			phase_q      <= phase_d;
			delay_q      <= delay_d;
			run_q        <= run_d;
			run_active_q <= run_active_d;
			chosen_q     <= chosen_d;
			motor_q      <= motor_d;
			dir_q        <= dir_d;
			led_q        <= led_d;
		end
	end

	// The motor is only energized between the settle delay and the stop.
	a_motor_phase: assert property (@(posedge clk) disable iff (!arst_n)
		motor_q |-> (phase_q == PH_WAIT_REL || phase_q == PH_REL_DEB || phase_q == PH_RUN))
		else $error("motor on outside the run phases");

	a_counters_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(delay_q <= SAT_MAX) && (run_q <= SAT_MAX))
		else $error("counter beyond saturation");

	a_led_code: assert property (@(posedge clk) disable iff (!arst_n)
		(led_q != 2'd3))
		else $error("invalid indicator code");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(phase_q) && $stable(delay_q) && $stable(run_q)))
		else $error("state changed without an item");

	a_idle_motor: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (!motor_q && !dir_q))
		else $error("relays not at rest in idle");

endmodule

@@ hdl/shutter_motor_touch_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_ready   tick, sample_valid, up_pressed, down_pressed
// output    out_valid / out_ready motor_drive, direction_up, led_mode, phase
// config    cfg_we                cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. An accepted item waits in
// the input register while the sequencer works out its update, and the result
// is loaded into the output register once that register is empty or being read.
// A stalled output holds its result and the input register keeps accepting
// until it is also full.
// Reset clears the sequencer to idle and loads the default register values.
module shutter_motor_touch_sequencer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       tick,
	input  logic                       sample_valid,
	input  logic                       up_pressed,
	input  logic                       down_pressed,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       motor_drive,
	output logic                       direction_up,
	output logic [1:0]                 led_mode,
	output logic [3:0]                 phase,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [smts_pkg::CNT_W-1:0] cfg_data
);
	import smts_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t result;
	result_t out_q;
	logic    out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks             <= RST_HOLD;
			cfg_q.run_limit_ticks        <= RST_RUN_LIMIT;
			cfg_q.switch_delay_ticks     <= RST_SWITCH;
			cfg_q.settle_ticks           <= RST_SETTLE;
			cfg_q.release_timeout_ticks  <= RST_REL_TIMEOUT;
			cfg_q.release_debounce_ticks <= RST_REL_DEB;
			cfg_q.post_delay_ticks       <= RST_POST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HOLD:        cfg_q.hold_ticks             <= cfg_data;
				REG_RUN_LIMIT:   cfg_q.run_limit_ticks        <= cfg_data;
				REG_SWITCH:      cfg_q.switch_delay_ticks     <= cfg_data;
				REG_SETTLE:      cfg_q.settle_ticks           <= cfg_data;
				REG_REL_TIMEOUT: cfg_q.release_timeout_ticks  <= cfg_data;
				REG_REL_DEB:     cfg_q.release_debounce_ticks <= cfg_data;
				REG_POST:        cfg_q.post_delay_ticks       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.tick         <= tick;
			item_s1.sample_valid <= sample_valid;
			item_s1.up_pressed   <= up_pressed;
			item_s1.down_pressed <= down_pressed;
		end
	end

	smts_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign motor_drive  = out_q.motor_drive;
	assign direction_up = out_q.direction_up;
	assign led_mode     = out_q.led_mode;
	assign phase        = out_q.phase;

endmodule
